### hdl/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL path decoder package
// Shared types, character codes and helper functions for the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Width of the byte counters, the length limit and the reported length.
  localparam int unsigned LenW = 16;

  // Reset value of the length limit register.
  localparam logic [LenW-1:0] MaxLenReset = LenW'(1023);

  // Character codes used by the decoder.
  localparam logic [7:0] ChQuest   = 8'h3F; // '?'
  localparam logic [7:0] ChPercent = 8'h25; // '%'
  localparam logic [7:0] ChSlash   = 8'h2F; // '/'
  localparam logic [7:0] ChZero    = 8'h30; // '0'
  localparam logic [7:0] ChNine    = 8'h39; // '9'
  localparam logic [7:0] ChUpA     = 8'h41; // 'A'
  localparam logic [7:0] ChUpF     = 8'h46; // 'F'
  localparam logic [7:0] ChUpZ     = 8'h5A; // 'Z'
  localparam logic [7:0] ChLowA    = 8'h61; // 'a'
  localparam logic [7:0] ChLowF    = 8'h66; // 'f'
  localparam logic [7:0] CaseDelta = 8'h20;

  // Decoder phase within one name.
  typedef enum logic [1:0] {
    PhNormal = 2'd0,  // plain text
    PhPct    = 2'd1,  // a percent sign was seen
    PhHex1   = 2'd2,  // the first hex digit was seen
    PhDrop   = 2'd3   // dropping bytes until the end of the name
  } phase_e;

  // Per-name decoder state.
  typedef struct packed {
    phase_e          phase;
    logic [3:0]      hex_high;
    logic            hex_bad;
    logic [LenW-1:0] taken;
    logic [LenW-1:0] emitted;
    logic            at_start;
  } upd_state_t;

  // Result of one decoding step.
  typedef struct packed {
    logic            fire;
    logic [7:0]      data;
    logic            has_byte;
    logic            last;
    logic [LenW-1:0] length;
  } upd_result_t;

  // State at reset and at the end of every name.
  localparam upd_state_t StateClear = '{
    phase:    PhNormal,
    hex_high: 4'd0,
    hex_bad:  1'b0,
    taken:    '0,
    emitted:  '0,
    at_start: 1'b1
  };

  // ASCII lowercase.
  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpA && b <= ChUpZ) begin
      r = b + CaseDelta;
    end
    return r;
  endfunction

  // Hex digit decode: bit 4 flags a bad digit, bits 3:0 hold the value.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'd0;
    r = 5'b10000;
    if (b >= ChZero && b <= ChNine) begin
      d = b - ChZero;
      r = {1'b0, d[3:0]};
    end else if (b >= ChUpA && b <= ChUpF) begin
      d = b - ChUpA + 8'd10;
      r = {1'b0, d[3:0]};
    end else if (b >= ChLowA && b <= ChLowF) begin
      d = b - ChLowA + 8'd10;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

endpackage

### hdl/upd_step.sv
// ----------------------------------------------------------------------------
// URL path decoder step
// Combinational decode of one source byte against the current name state.
// ----------------------------------------------------------------------------
module upd_step (
  input  upd_pkg::upd_state_t        state_i,
  input  logic [upd_pkg::LenW-1:0]   max_length_i,
  input  logic [7:0]                 in_byte_i,
  input  logic                       in_last_i,
  input  logic                       empty_name_i,
  output upd_pkg::upd_state_t        state_o,
  output upd_pkg::upd_result_t       result_o
);

  logic                     qmark_start;
  logic                     dropping;
  logic [upd_pkg::LenW-1:0] taken_inc;
  logic                     end_here;
  logic [4:0]               hex_lo;
  logic [4:0]               hex_hi_cur;
  logic [7:0]               hex_byte;

  // Shared conditions of the step.
  assign qmark_start = state_i.at_start && (in_byte_i == upd_pkg::ChQuest);
  assign dropping    = !qmark_start &&
                       ((state_i.phase == upd_pkg::PhDrop) || (state_i.taken >= max_length_i));
  assign taken_inc   = state_i.taken + upd_pkg::LenW'(1);
  assign end_here    = in_last_i || (taken_inc >= max_length_i);
  assign hex_lo      = upd_pkg::hex_value(in_byte_i);
  assign hex_hi_cur  = upd_pkg::hex_value(in_byte_i);
  assign hex_byte    = {state_i.hex_high, hex_lo[3:0]};

  // Result of the step.
  always_comb begin
    result_o          = '0;
    if (empty_name_i) begin
      // An empty name is a complete name of its own, whatever came before.
      result_o.fire     = 1'b1;
      result_o.has_byte = 1'b1;
      result_o.data     = upd_pkg::ChSlash;
      result_o.last     = 1'b1;
      result_o.length   = upd_pkg::LenW'(1);
    end else if (qmark_start) begin
      result_o.fire     = 1'b1;
      result_o.has_byte = 1'b1;
      result_o.data     = upd_pkg::ChSlash;
      result_o.last     = in_last_i;
    end else if (dropping) begin
      result_o.fire     = in_last_i;
      result_o.last     = in_last_i;
    end else begin
      unique case (state_i.phase)
        upd_pkg::PhNormal: begin
          if (in_byte_i == upd_pkg::ChPercent) begin
            if (end_here) begin
              result_o.fire     = 1'b1;
              result_o.has_byte = 1'b1;
              result_o.data     = upd_pkg::ChZero;
              result_o.last     = in_last_i;
            end
          end else begin
            result_o.fire     = 1'b1;
            result_o.has_byte = 1'b1;
            result_o.data     = upd_pkg::fold_lower(in_byte_i);
            result_o.last     = in_last_i;
          end
        end
        upd_pkg::PhPct: begin
          if (end_here) begin
            result_o.fire     = 1'b1;
            result_o.has_byte = 1'b1;
            result_o.data     = upd_pkg::ChZero;
            result_o.last     = in_last_i;
          end
        end
        upd_pkg::PhHex1: begin
          result_o.fire     = 1'b1;
          result_o.has_byte = 1'b1;
          result_o.last     = in_last_i;
          // A bad digit or a zero value decodes to the digit zero.
          if (state_i.hex_bad || hex_lo[4] || (hex_byte == 8'd0)) begin
            result_o.data = upd_pkg::ChZero;
          end else begin
            result_o.data = upd_pkg::fold_lower(hex_byte);
          end
        end
        default: begin
          result_o.fire = 1'b0;
        end
      endcase
    end
    // The final result reports the count including its own byte.
    if (result_o.last && !empty_name_i) begin
      result_o.length = state_i.emitted + upd_pkg::LenW'(result_o.has_byte);
    end
  end

  // Next state of the name.
  always_comb begin
    state_o          = state_i;
    state_o.at_start = 1'b0;
    state_o.emitted  = state_i.emitted + upd_pkg::LenW'(result_o.has_byte);
    if (empty_name_i || (result_o.fire && result_o.last)) begin
      state_o = upd_pkg::StateClear;
    end else if (qmark_start) begin
      state_o.phase = upd_pkg::PhDrop;
    end else if (!dropping) begin
      state_o.taken = taken_inc;
      unique case (state_i.phase)
        upd_pkg::PhNormal: begin
          if (in_byte_i == upd_pkg::ChPercent) begin
            state_o.phase = end_here ? upd_pkg::PhDrop : upd_pkg::PhPct;
          end else if (end_here) begin
            state_o.phase = upd_pkg::PhDrop;
          end
        end
        upd_pkg::PhPct: begin
          state_o.hex_bad  = hex_hi_cur[4];
          state_o.hex_high = hex_hi_cur[4] ? 4'd0 : hex_hi_cur[3:0];
          state_o.phase    = end_here ? upd_pkg::PhDrop : upd_pkg::PhHex1;
        end
        upd_pkg::PhHex1: begin
          state_o.phase = end_here ? upd_pkg::PhDrop : upd_pkg::PhNormal;
        end
        default: begin
          state_o.phase = upd_pkg::PhDrop;
        end
      endcase
    end
  end

endmodule

### hdl/url_path_percent_decoder.sv
// ----------------------------------------------------------------------------
// URL path percent decoder
// Decodes percent escapes and lowercases a URL path, one byte per request.
// ----------------------------------------------------------------------------
// The block takes one source byte per ready cycle and gives at most one
// result per byte, in the cycle after the request is accepted. Each request is
// decoded in a single pass against the name state and the result is held in
// an output register; a new request is accepted in every cycle while that
// register is empty or being read, so the sustained rate is one byte per
// cycle, limited only by the output side. A name that is empty or starts
// with '?' gives "/". Only the first max_length bytes of a name count. The
// result that ends a name carries its output length. Write max_length only
// while the block is idle.
module url_path_percent_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration.
  input  logic                      cfg_we_i,
  input  logic [upd_pkg::LenW-1:0]  cfg_wdata_i,
  // Input requests.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  input  logic                      empty_name_i,
  // Results.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      has_byte_o,
  output logic                      out_last_o,
  output logic [upd_pkg::LenW-1:0]  name_length_o
);

  upd_pkg::upd_state_t       state_q, state_d;
  upd_pkg::upd_result_t      result;
  logic [upd_pkg::LenW-1:0]  max_length_q;
  logic                      out_valid_q;
  upd_pkg::upd_result_t      out_q;
  logic                      accept;

  // Accept while the output register is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode of the current request.
  upd_step u_step (
    .state_i      (state_q),
    .max_length_i (max_length_q),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .empty_name_i (empty_name_i),
    .state_o      (state_d),
    .result_o     (result)
  );

  // Length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= upd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  // Name state advances on every accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= upd_pkg::StateClear;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && result.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept && result.fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.data;
  assign has_byte_o    = out_q.has_byte;
  assign out_last_o    = out_q.last;
  assign name_length_o = out_q.length;

endmodule

### verif/tb_url_path_percent_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL path percent decoder testbench
// Feeds names byte by byte, predicts every decoded result in a scoreboard,
// and checks each result in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_url_path_percent_decoder;

  // One decoded result as the block reports it.
  typedef struct {
    logic [7:0]               data;
    logic                     has_byte;
    logic                     last;
    logic [upd_pkg::LenW-1:0] length;
  } decoded_t;

  // Scoreboard: tracks the name state and holds the decoded results still due.
  class decode_scoreboard;
    decoded_t                 expected_q[$];
    int                       errors;
    logic [upd_pkg::LenW-1:0] max_len;
    upd_pkg::phase_e          phase;
    logic [3:0]               hex_hi;
    logic                     hex_bad;
    logic [upd_pkg::LenW-1:0] taken;
    logic [upd_pkg::LenW-1:0] emitted;
    logic                     at_start;

    function new();
      errors  = 0;
      max_len = upd_pkg::MaxLenReset;
      restart_name();
    endfunction

    function void restart_name();
      phase    = upd_pkg::PhNormal;
      hex_hi   = 4'd0;
      hex_bad  = 1'b0;
      taken    = '0;
      emitted  = '0;
      at_start = 1'b1;
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Returns the digit value, or -1 when the byte is not a hex digit.
    function int hex_digit(logic [7:0] c);
      int d;
      d = -1;
      if (c >= "0" && c <= "9") d = int'(c - "0");
      else if (c >= "a" && c <= "f") d = int'(c - "a") + 10;
      else if (c >= "A" && c <= "F") d = int'(c - "A") + 10;
      return d;
    endfunction

    function void emit(logic has, logic [7:0] c, logic last);
      decoded_t r;
      if (has) emitted = emitted + 1'b1;
      r.data     = has ? c : 8'd0;
      r.has_byte = has;
      r.last     = last;
      r.length   = last ? emitted : '0;
      expected_q.push_back(r);
      if (last) restart_name();
    endfunction

    // Advance the name state by one accepted request.
    function void note_request(logic [7:0] c, logic last, logic empty);
      logic       end_here;
      int         d;
      logic [7:0] val;
      if (empty) begin
        restart_name();
        emit(1'b1, upd_pkg::ChSlash, 1'b1);
        return;
      end
      if (at_start) begin
        at_start = 1'b0;
        if (c == upd_pkg::ChQuest) begin
          phase = upd_pkg::PhDrop;
          emit(1'b1, upd_pkg::ChSlash, last);
          return;
        end
      end
      // Dropped bytes only matter when they close the name.
      if (phase == upd_pkg::PhDrop || taken >= max_len) begin
        if (last) emit(1'b0, 8'd0, 1'b1);
        return;
      end
      taken    = taken + 1'b1;
      end_here = last || taken >= max_len;
      case (phase)
        upd_pkg::PhNormal: begin
          if (c == upd_pkg::ChPercent) begin
            if (end_here) begin
              phase = last ? upd_pkg::PhNormal : upd_pkg::PhDrop;
              emit(1'b1, upd_pkg::ChZero, last);
            end else begin
              phase = upd_pkg::PhPct;
            end
          end else begin
            if (end_here && !last) phase = upd_pkg::PhDrop;
            emit(1'b1, fold_case(c), last);
          end
        end
        upd_pkg::PhPct: begin
          d       = hex_digit(c);
          hex_bad = d < 0;
          hex_hi  = (d < 0) ? 4'd0 : d[3:0];
          if (end_here) begin
            phase = last ? upd_pkg::PhNormal : upd_pkg::PhDrop;
            emit(1'b1, upd_pkg::ChZero, last);
          end else begin
            phase = upd_pkg::PhHex1;
          end
        end
        default: begin
          d     = hex_digit(c);
          phase = (end_here && !last) ? upd_pkg::PhDrop : upd_pkg::PhNormal;
          if (hex_bad || d < 0) begin
            emit(1'b1, upd_pkg::ChZero, last);
          end else begin
            val = {hex_hi, d[3:0]};
            emit(1'b1, (val == 8'd0) ? upd_pkg::ChZero : fold_case(val), last);
          end
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest one still due.
    function void check_result(logic [7:0] data, logic has, logic last,
                               logic [upd_pkg::LenW-1:0] length);
      decoded_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result byte=%h has=%b last=%b len=%0d",
                   data, has, last, length);
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data || has !== e.has_byte || last !== e.last ||
          length !== e.length) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected byte=%h has=%b last=%b len=%0d,",
                   e.data, e.has_byte, e.last, e.length,
                   " got byte=%h has=%b last=%b len=%0d",
                   data, has, last, length);
      end
    endfunction
  endclass

  localparam int HoldCycles = 64;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [upd_pkg::LenW-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [7:0]               in_byte_i;
  logic                     in_last_i;
  logic                     empty_name_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [7:0]               out_byte_o;
  logic                     has_byte_o;
  logic                     out_last_o;
  logic [upd_pkg::LenW-1:0] name_length_o;

  decode_scoreboard sb;
  bit               in_steady;
  bit               out_steady;
  bit               hold_off_req;
  int               sent;

  url_path_percent_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .empty_name_i  (empty_name_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .has_byte_o    (has_byte_o),
    .out_last_o    (out_last_o),
    .name_length_o (name_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Offer one request and wait until the block takes it.
  task automatic send_req(logic [7:0] c, logic last, logic empty);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= c;
    in_last_i    <= last;
    empty_name_i <= empty;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(c, last, empty);
    sent++;
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      send_req(s[i], close && (i == s.len() - 1), 1'b0);
  endtask

  // Let every pending result drain, then idle so that requests that produce
  // none are through.
  task automatic wait_idle(int limit);
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0 && n < limit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_max_len(logic [upd_pkg::LenW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_len = v;
  endtask

  // One random name: plain text, case mix, escapes good and bad, sometimes
  // a leading '?', an empty name, or a name abandoned partway.
  task automatic random_name();
    logic [7:0] text[$];
    string      hex_chars;
    int         len;
    int         k;
    int         cut;
    hex_chars = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 99) < 6) begin
      send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    if ($urandom_range(0, 99) < 8) text.push_back(upd_pkg::ChQuest);
    while (text.size() < len) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        text.push_back(upd_pkg::ChPercent);
        repeat (2) begin
          if ($urandom_range(0, 4) != 0)
            text.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
          else
            text.push_back(8'($urandom_range(0, 255)));
        end
      end else if (k < 55) begin
        text.push_back($urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
                                            : 8'($urandom_range("a", "z")));
      end else begin
        text.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (text.size() > len) void'(text.pop_back());
    // A broken name is cut short by an empty name.
    cut = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < cut; i++)
      send_req(text[i], (cut == len) && (i == len - 1), 1'b0);
    if (cut < len)
      send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      stall = pick_gap(out_steady);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_byte_o, has_byte_o, out_last_o, name_length_o);
  end

  // Overall time limit.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [upd_pkg::LenW-1:0] max_settings[$];
    int                       target;
    bit                       hold_done;
    sb           = new();
    sent         = 0;
    hold_done    = 1'b0;
    hold_off_req = 1'b0;
    in_steady    = 1'b0;
    out_steady   = 1'b0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    in_byte_i    <= 8'd0;
    in_last_i    <= 1'b0;
    empty_name_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed names with the reset length limit.
    send_req(8'hFF, 1'b1, 1'b1);
    send_text("?ab", 1'b1);
    send_text("Z%4a%00", 1'b1);
    send_text("%G1", 1'b1);
    send_text("%", 1'b1);
    send_text("%4", 1'b1);
    send_req(8'h00, 1'b0, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    // A limit change in the middle of a name.
    send_text("ab", 1'b0);
    wait_idle(1000);
    write_max_len(upd_pkg::LenW'(1));
    send_text("c", 1'b1);
    // An escape cut short by the length limit.
    wait_idle(1000);
    write_max_len(upd_pkg::LenW'(2));
    send_text("%41", 1'b1);
    wait_idle(1000);

    // Random names over a range of length limits.
    max_settings = '{upd_pkg::LenW'(5), upd_pkg::LenW'(0), upd_pkg::LenW'(65535),
                     upd_pkg::LenW'(1), upd_pkg::LenW'(2), upd_pkg::LenW'(3),
                     upd_pkg::LenW'(8), upd_pkg::LenW'($urandom_range(4, 20)),
                     upd_pkg::LenW'(1023)};
    foreach (max_settings[p]) begin
      write_max_len(max_settings[p]);
      in_steady  = (p == 3) || ($urandom_range(0, 3) == 0);
      out_steady = (p == 3) || ($urandom_range(0, 3) == 0);
      target = sent + 165;
      while (sent < target) begin
        // One long receiver hold-off while names keep coming.
        if (p == 2 && !hold_done && sent > target - 120) begin
          hold_off_req = 1'b1;
          hold_done    = 1'b1;
        end
        random_name();
      end
      wait_idle(2000);
    end

    repeat (10) @(posedge clk_i);
    sb.errors += sb.expected_q.size();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/upd_pkg.sv
hdl/upd_step.sv
hdl/url_path_percent_decoder.sv
verif/tb_url_path_percent_decoder.sv
